// File: hw/rtl/svrc_pkg.sv
`timescale 1ns / 1ps

package svrc_pkg;

	// Ring capacity used when the top level is not overridden.
	localparam int LINE_SLOTS_DEFAULT = 64;

	// Field widths of the transfer payloads and of the configuration register.
	localparam int OP_W     = 2;
	localparam int AMOUNT_W = 7;
	localparam int HEIGHT_W = 7;
	localparam int SLOT_OUT_W  = 6;
	localparam int COUNT_OUT_W = 7;
	localparam int NOTICE_W    = 2;

	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd16;

	// Entries of the command queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD_LINE    = 2'd0,
		OP_SCROLL_UP   = 2'd1,
		OP_SCROLL_DOWN = 2'd2,
		OP_IDLE        = 2'd3
	} op_e;

	typedef enum logic [NOTICE_W-1:0] {
		NOTICE_NONE  = 2'd0,
		NOTICE_RAISE = 2'd1,
		NOTICE_CLEAR = 2'd2
	} notice_e;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [AMOUNT_W-1:0] scroll_amount;
	} in_item_t;

	typedef struct packed {
		logic [SLOT_OUT_W-1:0]  write_slot;
		logic [SLOT_OUT_W-1:0]  top_line;
		logic [SLOT_OUT_W-1:0]  bottom_line;
		logic [COUNT_OUT_W-1:0] line_count;
		logic                   scrolled_up;
		logic [NOTICE_W-1:0]    notice;
	} out_item_t;

	// Classified command handed from the front to the back.
	typedef struct packed {
		op_e                 op;
		logic [AMOUNT_W-1:0] amount;
		logic                amount_nz;
	} cmd_t;

endpackage

// File: hw/rtl/scrollback_viewport_ring_controller.sv
`timescale 1ns / 1ps

// Scrollback viewport ring controller: keeps the head, tail, line count and
// viewport pointers of a ring of LINE_SLOTS text line slots.
// The in channel carries one command per transfer (add line, scroll up,
// scroll down); the out channel returns exactly one result per command with
// the slot to write, the new viewport top and bottom, the line count, the
// scrolled flag and the unread notice code.
// The cfg channel writes the viewport height; it is always ready and should
// only be used while no command is in flight.
// On its way to the out channel a command first loads the decode register in
// the front, is then written into the two-entry command queue, and finally
// runs the pointer update in the back, which registers the result. The back
// takes one command per cycle while the out channel is not stalled, a rate
// set by the pointer update loop that closes within the back.
// Reset clears all pointers, the count and both flags, and loads a viewport
// height of 16. When the receiver stalls, the result holds in the output
// register, the queue fills, and in_ready drops only once the front register
// and queue can take no more; nothing is lost.
module scrollback_viewport_ring_controller
	import svrc_pkg::*;
#(
	parameter int LINE_SLOTS = LINE_SLOTS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [HEIGHT_W-1:0] cfg_data
);

	logic                q_push_valid;
	logic                q_push_ready;
	cmd_t                q_push_data;
	logic                q_pop_valid;
	logic                q_pop_ready;
	cmd_t                q_pop_data;
	logic [HEIGHT_W-1:0] height_q;

	// The height register takes every write transfer immediately.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			height_q <= cfg_data;
		end
	end

	// Front: accepts commands and classifies them.
	svrc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cmd_valid (q_push_valid),
		.cmd_ready (q_push_ready),
		.cmd_data  (q_push_data)
	);

	// Short queue that lets the front keep accepting while the back stalls.
	svrc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	// Back: owns the ring pointers and produces the registered result.
	svrc_back #(
		.LINE_SLOTS (LINE_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.height    (height_q),
		.cmd_valid (q_pop_valid),
		.cmd_ready (q_pop_ready),
		.cmd_data  (q_pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: hw/rtl/svrc_front.sv
`timescale 1ns / 1ps

module svrc_front
	import svrc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output cmd_t     cmd_data
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_dec;

	// Decode the operation code into a command and flag a nonzero scroll.
	always_comb begin
		cmd_dec.amount    = in_data.scroll_amount;
		cmd_dec.amount_nz = |in_data.scroll_amount;
		unique case (in_data.operation)
			OP_ADD_LINE: begin
				cmd_dec.op        = OP_ADD_LINE;
				cmd_dec.amount_nz = 1'b0;
			end
			OP_SCROLL_UP:   cmd_dec.op = OP_SCROLL_UP;
			OP_SCROLL_DOWN: cmd_dec.op = OP_SCROLL_DOWN;
			default: begin
				cmd_dec.op        = OP_IDLE;
				cmd_dec.amount_nz = 1'b0;
			end
		endcase
	end

	assign in_ready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd_data  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_dec;
		end
	end

endmodule

// File: hw/rtl/svrc_queue.sv
`timescale 1ns / 1ps

module svrc_queue
	import svrc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hw/rtl/svrc_back.sv
`timescale 1ns / 1ps

module svrc_back
	import svrc_pkg::*;
#(
	parameter int LINE_SLOTS = LINE_SLOTS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [HEIGHT_W-1:0] height,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  cmd_t                cmd_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_data
);

	localparam int SLOT_W = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
	localparam int CNT_W  = $clog2(LINE_SLOTS + 1);
	localparam int CMP_W  = (CNT_W > HEIGHT_W) ? CNT_W : HEIGHT_W;
	localparam int AMT_W  = (SLOT_W > AMOUNT_W) ? SLOT_W : AMOUNT_W;
	localparam logic [SLOT_W:0]  SLOTS_X  = (SLOT_W + 1)'(LINE_SLOTS);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LINE_SLOTS);
	localparam logic [SLOT_W-1:0] ONE_SLOT = SLOT_W'(1);

	function automatic logic [SLOT_W-1:0] ring_add(input logic [SLOT_W-1:0] a,
		input logic [SLOT_W-1:0] b);
		logic [SLOT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= SLOTS_X) begin
			s = s - SLOTS_X;
		end
		return s[SLOT_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] ring_sub(input logic [SLOT_W-1:0] a,
		input logic [SLOT_W-1:0] b);
		logic [SLOT_W:0] s;
		if (a >= b) begin
			s = {1'b0, a} - {1'b0, b};
		end else begin
			s = {1'b0, a} + SLOTS_X - {1'b0, b};
		end
		return s[SLOT_W-1:0];
	endfunction

	function automatic logic [SLOT_OUT_W-1:0] fit_slot(input logic [SLOT_W-1:0] v);
		logic [SLOT_W+SLOT_OUT_W-1:0] t;
		t = {{SLOT_OUT_W{1'b0}}, v};
		return t[SLOT_OUT_W-1:0];
	endfunction

	function automatic logic [COUNT_OUT_W-1:0] fit_count(input logic [CNT_W-1:0] v);
		logic [CNT_W+COUNT_OUT_W-1:0] t;
		t = {{COUNT_OUT_W{1'b0}}, v};
		return t[COUNT_OUT_W-1:0];
	endfunction

	logic [SLOT_W-1:0] head_q, tail_q, top_q, bottom_q;
	logic [CNT_W-1:0]  held_q;
	logic              scrolled_q, unread_q;

	logic [SLOT_W-1:0] head_n, tail_n, top_n, bottom_n;
	logic [CNT_W-1:0]  held_n;
	logic              scrolled_n, unread_n;
	logic [NOTICE_W-1:0] notice_n;

	logic [SLOT_W-1:0] hidden;
	logic [SLOT_W-1:0] shift;
	logic [AMT_W-1:0]  amt_x;
	logic [AMT_W-1:0]  hid_x;

	logic      out_valid_q;
	out_item_t out_data_q;
	logic      step;

	assign cmd_ready = !out_valid_q || out_ready;
	assign step      = cmd_valid && cmd_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Hidden lines on the side that the scroll moves toward, and the clamped shift.
	always_comb begin
		if (cmd_data.op == OP_SCROLL_UP) begin
			hidden = ring_sub(top_q, tail_q);
		end else begin
			hidden = ring_sub(head_q, bottom_q);
		end
		amt_x = AMT_W'(cmd_data.amount);
		hid_x = AMT_W'(hidden);
		if (!cmd_data.amount_nz) begin
			shift = '0;
		end else if (amt_x < hid_x) begin
			shift = amt_x[SLOT_W-1:0];
		end else begin
			shift = hidden;
		end
	end

	always_comb begin
		head_n     = head_q;
		tail_n     = tail_q;
		held_n     = held_q;
		top_n      = top_q;
		bottom_n   = bottom_q;
		scrolled_n = scrolled_q;
		unread_n   = unread_q;
		notice_n   = NOTICE_NONE;
		unique case (cmd_data.op)
			OP_ADD_LINE: begin
				if (held_q == FULL_CNT) begin
					tail_n = ring_add(tail_q, ONE_SLOT);
				end else begin
					held_n = held_q + 1'b1;
				end
				head_n = ring_add(head_q, ONE_SLOT);
				if (!scrolled_q) begin
					bottom_n = head_n;
					if (CMP_W'(held_n) > CMP_W'(height)) begin
						top_n = ring_add(top_q, ONE_SLOT);
					end
				end else if (!unread_q) begin
					unread_n = 1'b1;
					notice_n = NOTICE_RAISE;
				end
			end
			OP_SCROLL_UP: begin
				if (shift != '0) begin
					scrolled_n = 1'b1;
					top_n      = ring_sub(top_q, shift);
					bottom_n   = ring_sub(bottom_q, shift);
				end
			end
			OP_SCROLL_DOWN: begin
				top_n    = ring_add(top_q, shift);
				bottom_n = ring_add(bottom_q, shift);
				if ((hidden == shift) && scrolled_q) begin
					if (unread_q) begin
						unread_n = 1'b0;
						notice_n = NOTICE_CLEAR;
					end
					scrolled_n = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			held_q      <= '0;
			top_q       <= '0;
			bottom_q    <= '0;
			scrolled_q  <= 1'b0;
			unread_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				head_q     <= head_n;
				tail_q     <= tail_n;
				held_q     <= held_n;
				top_q      <= top_n;
				bottom_q   <= bottom_n;
				scrolled_q <= scrolled_n;
				unread_q   <= unread_n;
			end
			if (cmd_ready) begin
				out_valid_q <= cmd_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q.write_slot  <= fit_slot(head_q);
			out_data_q.top_line    <= fit_slot(top_n);
			out_data_q.bottom_line <= fit_slot(bottom_n);
			out_data_q.line_count  <= fit_count(held_n);
			out_data_q.scrolled_up <= scrolled_n;
			out_data_q.notice      <= notice_n;
		end
	end

endmodule

// File: hw/rtl/svrc_checker.sv
`timescale 1ns / 1ps

module svrc_checker
	import svrc_pkg::*;
#(
	parameter int LINE_SLOTS = LINE_SLOTS_DEFAULT
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input in_item_t            in_data,
	input logic                out_valid,
	input logic                out_ready,
	input out_item_t           out_data
);

	// An offered command must hold until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("command changed or vanished while waiting");

	// A stalled result must hold until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or vanished while stalled");

	// An unread notice is only raised while the view is scrolled up.
	a_raise_scrolled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.notice == NOTICE_RAISE) |-> out_data.scrolled_up)
		else $error("unread notice raised while following newest line");

	// Clearing the notice means the view is back at the bottom.
	a_clear_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.notice == NOTICE_CLEAR) |-> !out_data.scrolled_up)
		else $error("notice cleared while still scrolled up");

	// The line count never exceeds the ring capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(out_data.line_count) <= LINE_SLOTS))
		else $error("line count above ring capacity");

endmodule

bind scrollback_viewport_ring_controller svrc_checker #(
	.LINE_SLOTS (LINE_SLOTS)
) u_svrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
